@@ hdl/rmdc_pkg.sv @@
// ----------------------------------------------------------------------------
// Ring message deframer package
// Shared widths, reset constants, parse phases and the result record.
// ----------------------------------------------------------------------------
package rmdc_pkg;

	localparam int SENDERS_DEFAULT    = 4;
	localparam int INDEX_BITS_DEFAULT = 16;

	localparam int SENDER_W = 2;
	localparam int WORD_W   = 32;
	localparam int POS_W    = 16;
	localparam int CHAN_W   = 15;
	localparam int SIZE_W   = 16;
	localparam int LEFT_W   = 15;
	localparam int RING_W   = 17;

	localparam logic [RING_W-1:0] RING_SIZE_RESET = 17'h10000;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_CHECK   = 2'd2
	} phase_t;

	typedef struct packed {
		logic [SENDER_W-1:0] msg_sender;
		logic [CHAN_W-1:0]   chan_num;
		logic                has_data;
		logic [SIZE_W-1:0]   size_or_entry;
		logic [POS_W-1:0]    payload_position;
		logic                check_ok;
		logic [POS_W-1:0]    end_position;
	} result_t;

endpackage

@@ hdl/rmdc_parser.sv @@
// ----------------------------------------------------------------------------
// Ring message deframer parser
// Input register and per-sender parse state, updated once per word.
// ----------------------------------------------------------------------------
module rmdc_parser #(
	parameter int SENDERS    = rmdc_pkg::SENDERS_DEFAULT,
	parameter int INDEX_BITS = rmdc_pkg::INDEX_BITS_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  logic                              in_valid,
	input  logic [rmdc_pkg::SENDER_W-1:0]     in_sender,
	input  logic [rmdc_pkg::WORD_W-1:0]       in_word,
	input  logic [rmdc_pkg::POS_W-1:0]        in_pos,
	input  logic [rmdc_pkg::RING_W-1:0]       ring_size,
	output logic                              res_valid_s2,
	output rmdc_pkg::result_t                 res_s2,
	output logic [INDEX_BITS:0]               dividend_s2,
	output logic [rmdc_pkg::RING_W-1:0]       divisor_s2
);

	localparam int SIDX_W = (SENDERS > 1) ? $clog2(SENDERS) : 1;
	localparam int PW     = INDEX_BITS + 1;

	logic                          in_valid_s1;
	logic [rmdc_pkg::SENDER_W-1:0] sender_s1;
	logic [rmdc_pkg::WORD_W-1:0]   word_s1;
	logic [rmdc_pkg::POS_W-1:0]    pos_s1;

	rmdc_pkg::phase_t              phase_q      [SENDERS];
	logic [rmdc_pkg::LEFT_W-1:0]   words_left_q [SENDERS];
	logic [rmdc_pkg::WORD_W-1:0]   check_q      [SENDERS];
	logic [rmdc_pkg::CHAN_W-1:0]   chan_q       [SENDERS];
	logic                          flag_q       [SENDERS];
	logic [rmdc_pkg::SIZE_W-1:0]   size_q       [SENDERS];
	logic [PW-1:0]                 start_q      [SENDERS];
	logic [rmdc_pkg::RING_W-1:0]   ring_q       [SENDERS];

	logic [SIDX_W-1:0]             sidx;
	logic                          sender_ok;
	logic                          upd;
	logic [INDEX_BITS-1:0]         pos_idx;
	logic [15:0]                   w1;
	logic [15:0]                   hi;
	logic [16:0]                   hi_round;
	logic [rmdc_pkg::WORD_W-1:0]   folded;
	logic [rmdc_pkg::WORD_W-1:0]   swapped;
	logic [rmdc_pkg::LEFT_W-1:0]   left_dec;
	logic [rmdc_pkg::LEFT_W-1:0]   hdr_left;

	rmdc_pkg::phase_t              nxt_phase;
	logic [rmdc_pkg::LEFT_W-1:0]   nxt_left;
	logic [rmdc_pkg::WORD_W-1:0]   nxt_check;
	logic                          hdr_we;
	logic                          emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (adv) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sender_s1 <= in_sender;
			word_s1   <= in_word;
			pos_s1    <= in_pos;
		end
	end

	assign sidx      = SIDX_W'(sender_s1);
	assign sender_ok = (int'(sender_s1) < SENDERS);
	assign upd       = adv && in_valid_s1 && sender_ok;
	assign pos_idx   = INDEX_BITS'(pos_s1);

	assign w1       = {word_s1[7:0], word_s1[15:8]};
	assign hi       = {word_s1[23:16], word_s1[31:24]};
	assign hi_round = {1'b0, hi} + 17'd3;
	assign hdr_left = hi_round[16:2];
	assign folded   = {check_q[sidx][0], check_q[sidx][rmdc_pkg::WORD_W-1:1]} ^ word_s1;
	assign swapped  = {word_s1[7:0], word_s1[15:8], word_s1[23:16], word_s1[31:24]};
	assign left_dec = words_left_q[sidx] - 1'b1;

	always_comb begin
		nxt_phase = rmdc_pkg::PH_HEADER;
		nxt_left  = '0;
		nxt_check = '0;
		hdr_we    = 1'b0;
		emit      = 1'b0;
		unique case (phase_q[sidx])
			rmdc_pkg::PH_PAYLOAD: begin
				nxt_check = folded;
				nxt_left  = left_dec;
				nxt_phase = (left_dec == '0) ? rmdc_pkg::PH_CHECK : rmdc_pkg::PH_PAYLOAD;
			end
			rmdc_pkg::PH_CHECK: begin
				emit = 1'b1;
			end
			default: begin
				hdr_we    = 1'b1;
				nxt_check = word_s1;
				if (w1[15]) begin
					nxt_left  = hdr_left;
					nxt_phase = (hdr_left != '0) ? rmdc_pkg::PH_PAYLOAD : rmdc_pkg::PH_CHECK;
				end else begin
					nxt_phase = rmdc_pkg::PH_CHECK;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SENDERS; i++) begin
				phase_q[i]      <= rmdc_pkg::PH_HEADER;
				words_left_q[i] <= '0;
				check_q[i]      <= '0;
			end
		end else if (upd) begin
			phase_q[sidx]      <= nxt_phase;
			words_left_q[sidx] <= nxt_left;
			check_q[sidx]      <= nxt_check;
		end
	end

	always_ff @(posedge clk) begin
		if (upd && hdr_we) begin
			chan_q[sidx]  <= w1[14:0];
			flag_q[sidx]  <= w1[15];
			size_q[sidx]  <= hi;
			start_q[sidx] <= PW'(pos_idx) + 1'b1;
			ring_q[sidx]  <= ring_size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (adv) begin
			res_valid_s2 <= upd && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2.msg_sender       <= sender_s1;
			res_s2.chan_num         <= chan_q[sidx];
			res_s2.has_data         <= flag_q[sidx];
			res_s2.size_or_entry    <= size_q[sidx];
			res_s2.payload_position <= '0;
			res_s2.check_ok         <= (swapped == check_q[sidx]);
			res_s2.end_position     <= rmdc_pkg::POS_W'(pos_idx);
			dividend_s2             <= start_q[sidx];
			divisor_s2              <= ring_q[sidx];
		end
	end

endmodule

@@ hdl/rmdc_mod_pipe.sv @@
// ----------------------------------------------------------------------------
// Ring message deframer wrap pipeline
// Reduces the payload position modulo the ring size, one quotient bit a stage.
// ----------------------------------------------------------------------------
module rmdc_mod_pipe #(
	parameter int INDEX_BITS = rmdc_pkg::INDEX_BITS_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic                        in_valid,
	input  rmdc_pkg::result_t           in_res,
	input  logic [INDEX_BITS:0]         in_dividend,
	input  logic [rmdc_pkg::RING_W-1:0] in_divisor,
	output logic                        out_valid,
	output rmdc_pkg::result_t           out_res
);

	localparam int PW     = INDEX_BITS + 1;
	localparam int STAGES = PW;
	localparam int WW     = PW + rmdc_pkg::RING_W;

	logic                        stage_valid_s [STAGES];
	rmdc_pkg::result_t           stage_res_s   [STAGES];
	logic [PW-1:0]               stage_rem_s   [STAGES];
	logic [rmdc_pkg::RING_W-1:0] stage_div_s   [STAGES];

	for (genvar j = 0; j < STAGES; j++) begin : g_stage
		localparam int SHIFT = STAGES - 1 - j;

		logic                        prev_valid;
		rmdc_pkg::result_t           prev_res;
		logic [PW-1:0]               prev_rem;
		logic [rmdc_pkg::RING_W-1:0] prev_div;
		logic [WW-1:0]               trial;
		logic [PW-1:0]               rem_next;

		if (j == 0) begin : g_first
			assign prev_valid = in_valid;
			assign prev_res   = in_res;
			assign prev_rem   = in_dividend;
			assign prev_div   = in_divisor;
		end else begin : g_next
			assign prev_valid = stage_valid_s[j-1];
			assign prev_res   = stage_res_s[j-1];
			assign prev_rem   = stage_rem_s[j-1];
			assign prev_div   = stage_div_s[j-1];
		end

		assign trial    = WW'(prev_div) << SHIFT;
		assign rem_next = (WW'(prev_rem) >= trial) ? (prev_rem - PW'(trial)) : prev_rem;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				stage_valid_s[j] <= 1'b0;
			end else if (adv) begin
				stage_valid_s[j] <= prev_valid;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				stage_res_s[j] <= prev_res;
				stage_rem_s[j] <= rem_next;
				stage_div_s[j] <= prev_div;
			end
		end
	end

	always_comb begin
		out_res                  = stage_res_s[STAGES-1];
		out_res.payload_position =
			rmdc_pkg::POS_W'(INDEX_BITS'(stage_rem_s[STAGES-1]));
	end

	assign out_valid = stage_valid_s[STAGES-1];

endmodule

@@ hdl/ring_message_deframer_checksum_unit.sv @@
// ----------------------------------------------------------------------------
// Ring message deframer with checksum
// Parses header, payload and check words per sender and reports each message.
// Throughput: one word per cycle while s_tready is high; the per-sender state
// update is a single read-modify-write, and the ring wrap runs in an
// INDEX_BITS + 1 stage pipeline.
// Reset: every sender expects a header, ring size becomes 65536, and the
// pipeline and output buffer are emptied at once.
// ----------------------------------------------------------------------------
module ring_message_deframer_checksum_unit #(
	parameter int SENDERS    = rmdc_pkg::SENDERS_DEFAULT,
	parameter int INDEX_BITS = rmdc_pkg::INDEX_BITS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [16:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // word[31:0], word_position[47:32]
	input  logic [1:0]  s_tuser,  // sender[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // chan_num[14:0], size_or_entry[30:15],
	                              // payload_position[46:31], check_ok[47],
	                              // end_position[63:48]
	output logic [2:0]  m_tuser   // msg_sender[1:0], has_data[2]
);

	logic [rmdc_pkg::RING_W-1:0] ring_size_q;
	logic                        adv;
	logic                        res_valid_s2;
	rmdc_pkg::result_t           res_s2;
	logic [INDEX_BITS:0]         dividend_s2;
	logic [rmdc_pkg::RING_W-1:0] divisor_s2;
	logic                        pipe_valid;
	rmdc_pkg::result_t           pipe_res;
	logic                        out_valid_q;
	rmdc_pkg::result_t           out_q;
	logic                        skid_valid_q;
	rmdc_pkg::result_t           skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_size_q <= rmdc_pkg::RING_SIZE_RESET;
		end else if (cfg_we) begin
			ring_size_q <= cfg_data;
		end
	end

	assign adv      = !skid_valid_q;
	assign s_tready = adv;

	rmdc_parser #(
		.SENDERS    (SENDERS),
		.INDEX_BITS (INDEX_BITS)
	) u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.in_valid     (s_tvalid),
		.in_sender    (s_tuser),
		.in_word      (s_tdata[31:0]),
		.in_pos       (s_tdata[47:32]),
		.ring_size    (ring_size_q),
		.res_valid_s2 (res_valid_s2),
		.res_s2       (res_s2),
		.dividend_s2  (dividend_s2),
		.divisor_s2   (divisor_s2)
	);

	rmdc_mod_pipe #(
		.INDEX_BITS (INDEX_BITS)
	) u_mod_pipe (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.in_valid    (res_valid_s2),
		.in_res      (res_s2),
		.in_dividend (dividend_s2),
		.in_divisor  (divisor_s2),
		.out_valid   (pipe_valid),
		.out_res     (pipe_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= pipe_valid;
			end
		end else if (pipe_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || m_tready) begin
			out_q <= skid_valid_q ? skid_q : pipe_res;
		end else if (pipe_valid && adv) begin
			skid_q <= pipe_res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q.end_position, out_q.check_ok, out_q.payload_position,
	                   out_q.size_or_entry, out_q.chan_num};
	assign m_tuser  = {out_q.has_data, out_q.msg_sender};

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("Skid buffer holds a word while the output register is empty.");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> $past(m_tvalid && !m_tready))
		else $error("Input stalled without a stalled output word.");

	a_drop_only_on_take: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(m_tvalid) |-> $past(m_tready))
		else $error("Output word withdrawn before it was taken.");

endmodule
